// ===== rtl/mbd_pkg.sv =====
`default_nettype none

package mbd_pkg;

  // Pixel channel geometry.
  localparam int unsigned CH_W  = 8;
  localparam int unsigned NUM_CH = 4;
  localparam int unsigned SUM_W = CH_W + 1;

  // One line-buffer entry: four pair sums and the left pixel's mask bit.
  localparam int unsigned ENTRY_W = NUM_CH * SUM_W + 1;

  // Configuration register file.
  localparam int unsigned LW_W      = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = LW_W;
  localparam logic [LW_W-1:0] LW_RESET = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_WIDTH     = 1'b0,
    CFG_FOUR_COMPONENTS = 1'b1
  } cfg_reg_e;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Held even-column pixel.
  typedef struct packed {
    chan_t [NUM_CH-1:0] ch;
    logic               mask;
  } pixel_t;

  // Line-buffer entry layout.
  typedef struct packed {
    logic              mask;
    sum_t [NUM_CH-1:0] sum;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/mbd_pix_in_if.sv =====
`default_nettype none

interface mbd_pix_in_if;
  import mbd_pkg::*;

  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;
  chan_t in_alpha;
  logic  in_mask;
  logic  in_frame_start;

  modport source (
    output valid, in_red, in_green, in_blue, in_alpha, in_mask, in_frame_start,
    input  ready
  );

  modport sink (
    input  valid, in_red, in_green, in_blue, in_alpha, in_mask, in_frame_start,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/mbd_pix_out_if.sv =====
`default_nettype none

interface mbd_pix_out_if;
  import mbd_pkg::*;

  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  chan_t out_alpha;
  logic  out_mask;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, out_mask,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, out_mask,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/mbd_ram.sv =====
`default_nettype none

module mbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]             wdata_i,
  input  wire logic                         re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port; read data holds when idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mip_box_downsampler.sv =====
`default_nettype none

// 2x2 box-filter mip reduction. Pixels of one level enter in row-major order
// at one beat per clock unless the output stalls; each complete 2x2 block
// yields one output beat whose channels are (sum + 2) / 4 and whose mask is
// the block's top-left mask bit. A result passes through stage 1 (the
// line-buffer read) and then the output register after the beat of its
// bottom-right pixel. Even rows write column-pair sums into a line buffer
// of MAX_WIDTH/2 entries; odd rows read them back through the buffer's
// single read port. The buffer needs no clearing after reset: every entry
// is written on an even row before an odd row reads it. A trailing odd
// column or row is dropped. Program level_width (0 acts as 1, values above
// MAX_WIDTH as MAX_WIDTH) and four_components only while idle; with four_components at 0 the alpha output is 0.
module mip_box_downsampler #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [mbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mbd_pkg::CFG_DAT_W-1:0] cfg_data_i,
  mbd_pix_in_if.sink                      pix_i,
  mbd_pix_out_if.source                   pix_o
);

  import mbd_pkg::*;

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CMPW = ((CW + 1) > LW_W) ? (CW + 1) : LW_W;
  localparam int unsigned ACCW = SUM_W + 2;

  // Configuration registers.
  logic [LW_W-1:0] level_width_q;
  logic            four_comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_width_q <= LW_RESET;
      four_comp_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_LEVEL_WIDTH:     level_width_q <= cfg_data_i[LW_W-1:0];
        CFG_FOUR_COMPONENTS: four_comp_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective width with out-of-range values clamped.
  logic [CMPW-1:0] lw_ext;
  logic [CMPW-1:0] width_eff;

  always_comb begin
    lw_ext = CMPW'(level_width_q);
    if (lw_ext == '0) begin
      width_eff = CMPW'(1);
    end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
      width_eff = CMPW'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext;
    end
  end

  // Position state and held even-column pixel.
  logic [CW-1:0] col_q, col_d;
  logic          odd_row_q, odd_row_d;
  pixel_t        hold_q, hold_d;

  // Stage 1 (line-buffer read in flight) and output register.
  logic                   s1_valid_q, s1_valid_d;
  sum_t [NUM_CH-1:0]      s1_part_q, s1_part_d;
  logic                   out_valid_q, out_valid_d;
  chan_t [NUM_CH-1:0]     out_ch_q, out_ch_d;
  logic                   out_mask_q, out_mask_d;

  logic              s1_move;
  logic              in_acc;
  logic [CW-1:0]     col_cur;
  logic              odd_cur;
  logic [CW-1:0]     col_shr;
  logic [AW-1:0]     slot;
  logic [CMPW-1:0]   col_inc;
  chan_t [NUM_CH-1:0] px;
  sum_t [NUM_CH-1:0] pair;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic              ram_we;
  logic              ram_re;
  logic [ACCW-1:0]   acc;

  assign s1_move     = s1_valid_q && (!out_valid_q || pix_o.ready);
  assign pix_i.ready = !s1_valid_q || !out_valid_q || pix_o.ready;
  assign in_acc      = pix_i.valid && pix_i.ready;

  assign px = {pix_i.in_alpha, pix_i.in_blue, pix_i.in_green, pix_i.in_red};

  // Frame start restarts the position before the pixel is used.
  assign col_cur = pix_i.in_frame_start ? '0 : col_q;
  assign odd_cur = pix_i.in_frame_start ? 1'b0 : odd_row_q;
  assign col_shr = col_cur >> 1;
  assign slot    = col_shr[AW-1:0];
  assign col_inc = CMPW'(col_cur) + CMPW'(1);

  // Pair sums of the held even pixel and the current odd pixel.
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      pair[k] = SUM_W'(hold_q.ch[k]) + SUM_W'(px[k]);
    end
  end

  assign wr_entry.sum  = pair;
  assign wr_entry.mask = hold_q.mask;

  assign ram_we = in_acc && col_cur[0] && !odd_cur;
  assign ram_re = in_acc && col_cur[0] && odd_cur;

  mbd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // Position and hold update on each accepted beat; stage 1 fills on a line-buffer read and empties as it advances.
  always_comb begin
    col_d      = col_q;
    odd_row_d  = odd_row_q;
    hold_d     = hold_q;
    s1_part_d  = s1_part_q;
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      if (!col_cur[0]) begin
        hold_d.ch   = px;
        hold_d.mask = pix_i.in_mask;
      end
      if (ram_re) begin
        s1_valid_d = 1'b1;
        s1_part_d  = pair;
      end
      if (col_inc >= width_eff) begin
        col_d     = '0;
        odd_row_d = !odd_cur;
      end else begin
        col_d     = col_inc[CW-1:0];
        odd_row_d = odd_cur;
      end
    end
  end

  // Block average from the stored pair sums and the stage-1 pair sums.
  always_comb begin
    out_ch_d    = out_ch_q;
    out_mask_d  = out_mask_q;
    out_valid_d = out_valid_q;
    acc         = '0;
    if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_move) begin
      out_valid_d = 1'b1;
      out_mask_d  = rd_entry.mask;
      for (int k = 0; k < NUM_CH; k++) begin
        acc = ACCW'(rd_entry.sum[k]) + ACCW'(s1_part_q[k]) + ACCW'(2);
        out_ch_d[k] = acc[ACCW-2:2];
      end
      if (!four_comp_q) begin
        out_ch_d[3] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      odd_row_q   <= 1'b0;
      hold_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      odd_row_q   <= odd_row_d;
      hold_q      <= hold_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_part_q  <= s1_part_d;
    out_ch_q   <= out_ch_d;
    out_mask_q <= out_mask_d;
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.out_red   = out_ch_q[0];
  assign pix_o.out_green = out_ch_q[1];
  assign pix_o.out_blue  = out_ch_q[2];
  assign pix_o.out_alpha = out_ch_q[3];
  assign pix_o.out_mask  = out_mask_q;

`ifndef SYNTH
  // A held line-buffer read must never be overwritten by a new read.
  a_no_read_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |-> !ram_re)
    else $error("line buffer read issued while stage 1 is stalled");

  // Even rows write and odd rows read, never both in one beat.
  a_rw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line buffer written and read in the same cycle");

  // Stage 1 only fills after an accepted odd-row, odd-column beat.
  a_s1_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(ram_re))
    else $error("stage 1 filled without a line buffer read");

  // The column never leaves the line.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(col_q) < CMPW'(MAX_WIDTH))
    else $error("column position out of range");

  // A result beat always follows a stage-1 advance.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("stage 1 advanced without a result beat");
`endif

endmodule

`default_nettype wire
